[rtl/eidr_pkg.sv]
// Package with shared types and constants of the enclosing interval depth resolver.
package eidr_pkg;

    localparam int TIME_W  = 64;
    localparam int DEPTH_W = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_LINE_START   = 2'd0;
    localparam logic [1:0] KIND_LINE_END     = 2'd1;
    localparam logic [1:0] KIND_OPT_LINE_END = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  end_time;
        logic [DEPTH_W-1:0] depth;
    } stack_entry_t;

endpackage

[rtl/enclosing_interval_depth_resolver_top.sv]
// Top level of the enclosing interval depth resolver: interval tables, stack and sequencer.
// Load, clear and unused opcodes leave the sequencer idle, so in_ready stays high.
// A query moves the cursor past each interval that starts before the query time, popping
// stack entries it covers and pushing it, then trims ended intervals and delivers the result.
// Each pass waits on the registered read port of the table and stack memories.
// Reset (rst_n low, asynchronous) empties the table and stack and clears the overflow flag.
module enclosing_interval_depth_resolver_top #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [eidr_pkg::TIME_W-1:0] slice_start,
    input  logic [eidr_pkg::TIME_W-1:0] slice_end,
    input  logic [eidr_pkg::DEPTH_W-1:0] slice_depth,
    input  logic [1:0]                  flow_kind,
    input  logic [eidr_pkg::TIME_W-1:0] query_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [eidr_pkg::DEPTH_W-1:0] resolved_depth,
    output logic                        overflowed
);

    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ADV_WAIT  = 3'd1;
    localparam logic [2:0] S_ADV_CHK   = 3'd2;
    localparam logic [2:0] S_POP       = 3'd3;
    localparam logic [2:0] S_POP_WAIT  = 3'd4;
    localparam logic [2:0] S_TRIM      = 3'd5;
    localparam logic [2:0] S_TRIM_WAIT = 3'd6;
    localparam logic [2:0] S_RESULT    = 3'd7;

    logic [eidr_pkg::TIME_W-1:0]  start_mem [MAX_INTERVALS];
    logic [eidr_pkg::TIME_W-1:0]  end_mem   [MAX_INTERVALS];
    logic [eidr_pkg::DEPTH_W-1:0] depth_mem [MAX_INTERVALS];
    eidr_pkg::stack_entry_t       stack_mem [MAX_INTERVALS];

    logic [eidr_pkg::TIME_W-1:0]  start_rd_reg;
    logic [eidr_pkg::TIME_W-1:0]  end_rd_reg;
    logic [eidr_pkg::DEPTH_W-1:0] depth_rd_reg;
    eidr_pkg::stack_entry_t       stack_rd_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             ovf_reg, ovf_next;
    logic [eidr_pkg::DEPTH_W-1:0] first_depth_reg, first_depth_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [eidr_pkg::TIME_W-1:0]  time_reg, time_next;
    logic                         out_valid_reg, out_valid_next;
    logic [eidr_pkg::DEPTH_W-1:0] res_depth_reg, res_depth_next;
    logic                         res_ovf_reg, res_ovf_next;

    logic             accept;
    logic             do_load;
    logic             do_push;
    logic             ahead;
    logic [CNT_W-1:0] sp_m1;
    logic [eidr_pkg::DEPTH_W-1:0] depth_sel;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign do_load   = accept && (opcode == eidr_pkg::OP_LOAD) && (count_reg < CNT_MAX);
    assign ahead     = (cursor_reg < count_reg);
    assign sp_m1     = sp_reg - CNT_W'(1);

    assign out_valid      = out_valid_reg;
    assign resolved_depth = res_depth_reg;
    assign overflowed     = res_ovf_reg;

    // The table read port always follows the cursor, the stack read port the top.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            start_mem[count_reg[IDX_W-1:0]] <= slice_start;
            end_mem[count_reg[IDX_W-1:0]]   <= slice_end;
            depth_mem[count_reg[IDX_W-1:0]] <= slice_depth;
        end
        start_rd_reg <= start_mem[cursor_reg[IDX_W-1:0]];
        end_rd_reg   <= end_mem[cursor_reg[IDX_W-1:0]];
        depth_rd_reg <= depth_mem[cursor_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[sp_reg[IDX_W-1:0]] <= '{end_time: end_rd_reg, depth: depth_rd_reg};
        end
        stack_rd_reg <= stack_mem[sp_m1[IDX_W-1:0]];
    end

    always_comb
    begin
        depth_sel = '0;
        case (kind_reg) inside
            eidr_pkg::KIND_LINE_START:
            begin
                if (ahead && (start_rd_reg == time_reg))
                    depth_sel = depth_rd_reg;
                else if (!ahead)
                    depth_sel = '0;
                else if (sp_reg == '0)
                    depth_sel = first_depth_reg;
                else
                    depth_sel = stack_rd_reg.depth;
            end
            eidr_pkg::KIND_LINE_END, eidr_pkg::KIND_OPT_LINE_END:
                depth_sel = ahead ? depth_rd_reg : '0;
            default:
                depth_sel = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cursor_next      = cursor_reg;
        sp_next          = sp_reg;
        ovf_next         = ovf_reg;
        first_depth_next = first_depth_reg;
        kind_next        = kind_reg;
        time_next        = time_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        res_depth_next   = res_depth_reg;
        res_ovf_next     = res_ovf_reg;
        do_push          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        eidr_pkg::OP_LOAD:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                    first_depth_next = slice_depth;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        eidr_pkg::OP_QUERY:
                        begin
                            kind_next  = flow_kind;
                            time_next  = query_time;
                            state_next = S_ADV_WAIT;
                        end
                        eidr_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                            sp_next     = '0;
                            ovf_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADV_WAIT:
                state_next = S_ADV_CHK;
            S_ADV_CHK:
            begin
                if (ahead && (start_rd_reg < time_reg))
                    state_next = S_POP;
                else
                    state_next = S_TRIM;
            end
            S_POP:
            begin
                if ((sp_reg != '0) && (stack_rd_reg.end_time <= end_rd_reg))
                begin
                    sp_next    = sp_m1;
                    state_next = S_POP_WAIT;
                end
                else
                begin
                    do_push     = 1'b1;
                    sp_next     = sp_reg + CNT_W'(1);
                    cursor_next = cursor_reg + CNT_W'(1);
                    state_next  = S_ADV_WAIT;
                end
            end
            S_POP_WAIT:
                state_next = S_POP;
            S_TRIM:
            begin
                if ((sp_reg != '0) && (stack_rd_reg.end_time < time_reg))
                begin
                    sp_next    = sp_m1;
                    state_next = S_TRIM_WAIT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_TRIM_WAIT:
                state_next = S_TRIM;
            S_RESULT:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    res_depth_next = depth_sel;
                    res_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            sp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            sp_reg        <= sp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_depth_reg <= first_depth_next;
        kind_reg        <= kind_next;
        time_reg        <= time_next;
        res_depth_reg   <= res_depth_next;
        res_ovf_reg     <= res_ovf_next;
    end

endmodule

[rtl/eidr_checker.sv]
// Port-level checker of the enclosing interval depth resolver and its bind.
module eidr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [eidr_pkg::TIME_W-1:0]  slice_start,
    input  logic [eidr_pkg::TIME_W-1:0]  slice_end,
    input  logic [eidr_pkg::DEPTH_W-1:0] slice_depth,
    input  logic [1:0]                   flow_kind,
    input  logic [eidr_pkg::TIME_W-1:0]  query_time,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [eidr_pkg::DEPTH_W-1:0] resolved_depth,
    input  logic                         overflowed
);

    // A query keeps the sequencer busy, so input ready drops after it is accepted.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == eidr_pkg::OP_QUERY) |=> !in_ready ##1 !in_ready)
        else $error("input ready returned too early after a query");

    // Loads and clears keep the input ready.
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((opcode == eidr_pkg::OP_LOAD) ||
        (opcode == eidr_pkg::OP_CLEAR)) |=> in_ready)
        else $error("input not ready after a load or clear");

    // A result is raised at the end of a query, while the input was still busy.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while no query was in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(resolved_depth) && $stable(overflowed))
        else $error("result changed while stalled");

endmodule

bind enclosing_interval_depth_resolver_top eidr_checker u_eidr_checker (.*);

[bench/enclosing_interval_depth_resolver_top_test.sv]
// Self-checking testbench for the enclosing interval depth resolver with a built-in predictor.
`timescale 1ns / 1ps

module enclosing_interval_depth_resolver_top_test;

    localparam int TABLE_DEPTH = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic [eidr_pkg::TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic [eidr_pkg::DEPTH_W-1:0] depth;
        logic                         ovf;
    } depth_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [1:0]                    opcode = OP_UNUSED;
    logic [eidr_pkg::TIME_W-1:0]   slice_start = '0;
    logic [eidr_pkg::TIME_W-1:0]   slice_end = '0;
    logic [eidr_pkg::DEPTH_W-1:0]  slice_depth = '0;
    logic [1:0]                    flow_kind = KIND_OTHER;
    logic [eidr_pkg::TIME_W-1:0]   query_time = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [eidr_pkg::DEPTH_W-1:0]  resolved_depth;
    logic                          overflowed;

    // Predicted track state.
    logic [eidr_pkg::TIME_W-1:0]   tbl_start [TABLE_DEPTH];
    logic [eidr_pkg::TIME_W-1:0]   tbl_end [TABLE_DEPTH];
    logic [eidr_pkg::DEPTH_W-1:0]  tbl_depth [TABLE_DEPTH];
    int unsigned         open_stack [TABLE_DEPTH];
    int unsigned         slice_count = 0;
    int unsigned         scan_pos = 0;
    int unsigned         open_top = 0;
    bit                  track_overflow = 1'b0;

    depth_result_t       pending_depths [$];
    depth_result_t       want;
    int unsigned         items_sent = 0;
    int unsigned         fail_count = 0;
    int unsigned         stall_left = 0;
    bit                  allow_idle = 1'b1;

    enclosing_interval_depth_resolver_top #(
        .MAX_INTERVALS(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .slice_start(slice_start),
        .slice_end(slice_end),
        .slice_depth(slice_depth),
        .flow_kind(flow_kind),
        .query_time(query_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .resolved_depth(resolved_depth),
        .overflowed(overflowed)
    );

    always #2 clk = ~clk;

    function automatic logic [eidr_pkg::TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Moves the scan position up to time t, then picks the depth for the flow kind.
    function automatic logic [eidr_pkg::DEPTH_W-1:0] resolve_depth(
        input logic [1:0] kind, input logic [eidr_pkg::TIME_W-1:0] t);
        bit ahead;
        while (scan_pos < slice_count && tbl_start[scan_pos] < t)
        begin
            while (open_top > 0 && tbl_end[open_stack[open_top - 1]] <= tbl_end[scan_pos])
                open_top--;
            if (open_top < TABLE_DEPTH)
            begin
                open_stack[open_top] = scan_pos;
                open_top++;
            end
            scan_pos++;
        end
        while (open_top > 0 && tbl_end[open_stack[open_top - 1]] < t)
            open_top--;
        ahead = scan_pos < slice_count;
        case (kind) inside
            eidr_pkg::KIND_LINE_START:
            begin
                if (ahead && tbl_start[scan_pos] == t)
                    return tbl_depth[scan_pos];
                if (!ahead)
                    return '0;
                if (open_top == 0)
                    return tbl_depth[0];
                return tbl_depth[open_stack[open_top - 1]];
            end
            eidr_pkg::KIND_LINE_END, eidr_pkg::KIND_OPT_LINE_END:
                return ahead ? tbl_depth[scan_pos] : '0;
            default:
                return '0;
        endcase
    endfunction

    function automatic void predict_item(input logic [1:0] op,
                                         input logic [eidr_pkg::TIME_W-1:0] s,
                                         input logic [eidr_pkg::TIME_W-1:0] e,
                                         input logic [eidr_pkg::DEPTH_W-1:0] d,
                                         input logic [1:0] k,
                                         input logic [eidr_pkg::TIME_W-1:0] t);
        depth_result_t r;
        case (op)
            eidr_pkg::OP_LOAD:
            begin
                if (slice_count < TABLE_DEPTH)
                begin
                    tbl_start[slice_count] = s;
                    tbl_end[slice_count] = e;
                    tbl_depth[slice_count] = d;
                    slice_count++;
                end
                else
                    track_overflow = 1'b1;
            end
            eidr_pkg::OP_QUERY:
            begin
                r.depth = resolve_depth(k, t);
                r.ovf = track_overflow;
                pending_depths.push_back(r);
            end
            eidr_pkg::OP_CLEAR:
            begin
                slice_count = 0;
                scan_pos = 0;
                open_top = 0;
                track_overflow = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    // Drives one transaction at a falling edge and returns at the edge that accepts it.
    task automatic send_item(input logic [1:0] op, input logic [eidr_pkg::TIME_W-1:0] s,
                             input logic [eidr_pkg::TIME_W-1:0] e,
                             input logic [eidr_pkg::DEPTH_W-1:0] d,
                             input logic [1:0] k, input logic [eidr_pkg::TIME_W-1:0] t);
        int unsigned gap;
        gap = (allow_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        slice_start <= s;
        slice_end <= e;
        slice_depth <= d;
        flow_kind <= k;
        query_time <= t;
        predict_item(op, s, e, d, k, t);
        if (op != OP_UNUSED)
            items_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_slice(input logic [eidr_pkg::TIME_W-1:0] s,
                              input logic [eidr_pkg::TIME_W-1:0] e,
                              input logic [eidr_pkg::DEPTH_W-1:0] d);
        send_item(eidr_pkg::OP_LOAD, s, e, d, 2'($urandom_range(0, 3)), rand64());
    endtask

    task automatic query_point(input logic [1:0] k, input logic [eidr_pkg::TIME_W-1:0] t);
        send_item(eidr_pkg::OP_QUERY, rand64(), rand64(), 16'($urandom), k, t);
    endtask

    task automatic clear_track();
        send_item(eidr_pkg::OP_CLEAR, rand64(), rand64(), 16'($urandom),
                  2'($urandom_range(0, 3)), rand64());
    endtask

    task automatic send_unused();
        send_item(OP_UNUSED, rand64(), rand64(), 16'($urandom), 2'($urandom_range(0, 3)),
                  rand64());
    endtask

    task automatic test_empty_track();
        query_point(eidr_pkg::KIND_LINE_START, '0);
        query_point(eidr_pkg::KIND_LINE_END, TIME_MAX);
        query_point(eidr_pkg::KIND_OPT_LINE_END, '0);
        query_point(KIND_OTHER, TIME_MAX);
        send_unused();
    endtask

    // Nested intervals with shared starts, a zero-length interval and a late append.
    task automatic test_nested_intervals();
        clear_track();
        load_slice('0, TIME_MAX, 16'hFFFF);
        load_slice(64'd10, 64'd100, 16'd1);
        load_slice(64'd10, 64'd50, 16'd2);
        load_slice(64'd20, 64'd30, 16'd3);
        load_slice(64'd200, 64'd300, 16'd0);
        load_slice(64'd300, 64'd300, 16'h7FFF);
        query_point(eidr_pkg::KIND_LINE_START, '0);
        query_point(eidr_pkg::KIND_LINE_END, '0);
        query_point(eidr_pkg::KIND_OPT_LINE_END, 64'd5);
        query_point(eidr_pkg::KIND_LINE_START, 64'd10);
        query_point(eidr_pkg::KIND_LINE_START, 64'd15);
        query_point(KIND_OTHER, 64'd25);
        send_unused();
        query_point(eidr_pkg::KIND_LINE_START, 64'd60);
        query_point(eidr_pkg::KIND_LINE_END, 64'd150);
        query_point(eidr_pkg::KIND_LINE_START, 64'd300);
        query_point(eidr_pkg::KIND_OPT_LINE_END, 64'd301);
        load_slice(TIME_MAX, TIME_MAX, 16'h8000);
        query_point(eidr_pkg::KIND_LINE_START, TIME_MAX);
        // Going back in time must not move anything.
        query_point(eidr_pkg::KIND_LINE_START, 64'd5);
        query_point(eidr_pkg::KIND_LINE_END, TIME_MAX);
    endtask

    // Fills the table with fully nested intervals so the stack grows to full depth.
    task automatic test_table_overflow();
        int unsigned i;
        clear_track();
        for (i = 0; i < TABLE_DEPTH + 3; i++)
            load_slice(64'(i) * 16, TIME_MAX - 64'(i), 16'(i) ^ 16'($urandom));
        query_point(eidr_pkg::KIND_LINE_START, 64'd16 * 600);
        query_point(eidr_pkg::KIND_LINE_END, 64'd16 * 600 + 1);
        query_point(eidr_pkg::KIND_LINE_START, 64'd16 * 900 + 3);
        query_point(eidr_pkg::KIND_LINE_START, TIME_MAX);
        query_point(eidr_pkg::KIND_OPT_LINE_END, TIME_MAX);
        clear_track();
        query_point(eidr_pkg::KIND_LINE_START, '0);
    endtask

    // Sorted tracks with random content, plus some unsorted loads, backward queries,
    // loads between queries and unused opcodes.
    task automatic test_random_tracks(input int unsigned n_items, input bit with_idle);
        int unsigned goal;
        int unsigned n_slices;
        int unsigned n_loaded;
        int unsigned n_queries;
        int unsigned i;
        int unsigned j;
        int unsigned pick;
        logic [eidr_pkg::TIME_W-1:0] base;
        logic [eidr_pkg::TIME_W-1:0] s;
        logic [eidr_pkg::TIME_W-1:0] cursor_t;
        logic [eidr_pkg::TIME_W-1:0] qt;
        logic [eidr_pkg::TIME_W-1:0] trk_start [64];
        logic [eidr_pkg::TIME_W-1:0] trk_end [64];
        logic [eidr_pkg::DEPTH_W-1:0] trk_depth [64];
        allow_idle = with_idle;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            clear_track();
            n_slices = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
            case ($urandom_range(0, 3))
                0: base = '0;
                1: base = {32'd0, $urandom};
                2: base = 64'hFFFF_FFFF_FFF0_0000;
                default: base = rand64() >> 1;
            endcase
            s = base;
            for (i = 0; i < n_slices; i++)
            begin
                s = s + $urandom_range(0, 6);
                trk_start[i] = s;
                trk_end[i] = ($urandom_range(0, 11) == 0) ? TIME_MAX
                                                          : s + $urandom_range(0, 200);
                trk_depth[i] = 16'($urandom);
            end
            n_loaded = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_slices) : n_slices;
            for (i = 0; i < n_loaded; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_slice(base + $urandom_range(0, 300), base + $urandom_range(0, 300),
                               16'($urandom));
                load_slice(trk_start[i], trk_end[i], trk_depth[i]);
            end
            cursor_t = base;
            n_queries = $urandom_range(1, 2 * n_slices + 2);
            for (j = 0; j < n_queries; j++)
            begin
                pick = $urandom_range(0, 24);
                if (n_loaded < n_slices && pick < 5)
                begin
                    load_slice(trk_start[n_loaded], trk_end[n_loaded], trk_depth[n_loaded]);
                    n_loaded++;
                end
                else if (pick == 5)
                    send_unused();
                else
                begin
                    if (n_slices > 0 && pick < 14)
                    begin
                        i = $urandom_range(0, n_slices - 1);
                        if (trk_start[i] > cursor_t)
                            cursor_t = trk_start[i];
                    end
                    else
                        cursor_t = cursor_t + $urandom_range(0, 40);
                    qt = cursor_t;
                    if (pick == 6)
                        qt = (cursor_t > 30) ? cursor_t - $urandom_range(1, 30) : '0;
                    query_point(2'($urandom_range(0, 3)), qt);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (allow_idle && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_depths.size() == 0)
            begin
                $error("unexpected result transaction: resolved_depth %0h overflowed %0b",
                       resolved_depth, overflowed);
                fail_count++;
            end
            else
            begin
                want = pending_depths.pop_front();
                if (resolved_depth !== want.depth)
                begin
                    $error("resolved_depth: expected %0h, actual %0h", want.depth,
                           resolved_depth);
                    fail_count++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_track();
        test_nested_intervals();
        test_table_overflow();
        test_random_tracks(400, 1'b1);
        test_random_tracks(100, 1'b0);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_depths.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_depths.size() != 0)
        begin
            $error("%0d result transactions never arrived", pending_depths.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
